[src/cea_pkg.sv]
// Shared types and addressing-mode codes for the effective address pipeline.
`default_nettype none
package cea_pkg;

    localparam logic [3:0] MODE_IMM  = 4'd0;
    localparam logic [3:0] MODE_ZP   = 4'd1;
    localparam logic [3:0] MODE_ZPX  = 4'd2;
    localparam logic [3:0] MODE_ZPY  = 4'd3;
    localparam logic [3:0] MODE_ABS  = 4'd4;
    localparam logic [3:0] MODE_ABSX = 4'd5;
    localparam logic [3:0] MODE_ABSY = 4'd6;
    localparam logic [3:0] MODE_IND  = 4'd7;
    localparam logic [3:0] MODE_INDX = 4'd8;
    localparam logic [3:0] MODE_INDY = 4'd9;
    localparam logic [3:0] MODE_REL  = 4'd10;

    // Stage two contents handed from the front pipe to the output stage.
    typedef struct packed {
        logic        valid;
        logic [3:0]  mode;
        logic [15:0] npc;
        logic [15:0] word;
        logic [15:0] ptrw;
        logic [15:0] abs_sum;
        logic [15:0] ptr_sum;
        logic [15:0] rel_sum;
        logic [7:0]  zp;
        logic [7:0]  zp_next;
    } t_s2;

endpackage
`default_nettype wire

[src/cpu6502_effective_address.sv]
// Top level of the 6502 effective address pipeline with the output stage.
//
// Usage: drive start high with a request beat (mode, PC, X, Y, the two
// operand bytes and the two pointer bytes). A beat is taken at every edge
// where start is high and busy is low; busy is always low, so one request
// can enter on every clock with no gaps.
// The result beat is driven on the o_ ports from the output stage register
// after the decode and add stages, marked by o_valid for one cycle.
// Throughput: one beat per cycle through the three-stage register chain
// (decode and index select, address adds, result select and page compare).
// The pointer addresses are pure functions of mode, operand bytes and X,
// so a caller may compute them ahead and supply the pointer bytes with
// the same request.
// Reset: i_rst_n low at an edge clears all valid bits, dropping any beat
// in flight; payload registers keep stale values.
// There is no back-pressure: the receiver must take each result beat in
// the cycle it is shown. The page-cross flag is per beat; make it sticky outside.
`default_nettype none
module cpu6502_effective_address (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [3:0]  i_action,
    input  wire logic [15:0] i_pc,
    input  wire logic [7:0]  i_index_x,
    input  wire logic [7:0]  i_index_y,
    input  wire logic [7:0]  i_operand_low,
    input  wire logic [7:0]  i_operand_high,
    input  wire logic [7:0]  i_pointer_low,
    input  wire logic [7:0]  i_pointer_high,
    output      logic        o_valid,
    output      logic [15:0] o_effective_address,
    output      logic [15:0] o_next_pc,
    output      logic        o_cross_page,
    output      logic [15:0] o_pointer_low_address,
    output      logic [15:0] o_pointer_high_address,
    output      logic        o_uses_pointer
);
    import cea_pkg::*;

    t_s2         s2;
    logic        r_valid;
    logic [15:0] r_ea;
    logic [15:0] r_npc;
    logic        r_crossed;
    logic [15:0] r_pla;
    logic [15:0] r_pha;
    logic        r_uses;
    logic [15:0] n_ea;
    logic        n_crossed;
    logic [15:0] n_pla;
    logic [15:0] n_pha;
    logic        n_uses;

    // Pipeline never stalls, so a beat is taken whenever start is high.
    assign busy = 1'b0;

    cea_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start),
        .i_action       (i_action),
        .i_pc           (i_pc),
        .i_index_x      (i_index_x),
        .i_index_y      (i_index_y),
        .i_operand_low  (i_operand_low),
        .i_operand_high (i_operand_high),
        .i_pointer_low  (i_pointer_low),
        .i_pointer_high (i_pointer_high),
        .o_s2           (s2)
    );

    // Stage three: select the result per mode and compare pages.
    always_comb begin
        n_ea      = 16'd0;
        n_crossed = 1'b0;
        n_pla     = 16'd0;
        n_pha     = 16'd0;
        n_uses    = 1'b0;
        unique case (s2.mode) inside
            MODE_IMM: begin
                n_ea = s2.npc - 16'd1;
            end
            MODE_ZP, MODE_ZPX, MODE_ZPY: begin
                n_ea = {8'd0, s2.zp};
            end
            MODE_ABS: begin
                n_ea = s2.word;
            end
            MODE_ABSX, MODE_ABSY: begin
                n_ea      = s2.abs_sum;
                n_crossed = (s2.abs_sum[15:8] != s2.word[15:8]);
            end
            MODE_IND: begin
                // Hold the high pointer byte inside the page of the low one.
                n_uses = 1'b1;
                n_pla  = s2.word;
                n_pha  = {s2.word[15:8], s2.word[7:0] + 8'd1};
                n_ea   = s2.ptrw;
            end
            MODE_INDX, MODE_INDY: begin
                // Zero-page pointer: wrap the high byte address in page zero.
                n_uses = 1'b1;
                n_pla  = {8'd0, s2.zp};
                n_pha  = {8'd0, s2.zp_next};
                if (s2.mode == MODE_INDX) begin
                    n_ea = s2.ptrw;
                end else begin
                    n_ea      = s2.ptr_sum;
                    n_crossed = (s2.ptr_sum[15:8] != s2.ptrw[15:8]);
                end
            end
            MODE_REL: begin
                n_ea = s2.rel_sum;
            end
            default: begin
                n_ea = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s2.valid;
        end
        r_ea      <= n_ea;
        r_npc     <= s2.npc;
        r_crossed <= n_crossed;
        r_pla     <= n_pla;
        r_pha     <= n_pha;
        r_uses    <= n_uses;
    end

    assign o_valid                = r_valid;
    assign o_effective_address    = r_ea;
    assign o_next_pc              = r_npc;
    assign o_cross_page           = r_crossed;
    assign o_pointer_low_address  = r_pla;
    assign o_pointer_high_address = r_pha;
    assign o_uses_pointer         = r_uses;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("accepted beat did not come out three cycles later");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 3))
        else $error("result beat without a matching request");

    a_ptr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_uses_pointer) |->
            (o_pointer_low_address == 16'd0 && o_pointer_high_address == 16'd0))
        else $error("pointer address reported for a mode without pointer");

    a_ptr_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_uses_pointer) |->
            (o_pointer_high_address[15:8] == o_pointer_low_address[15:8] &&
             o_pointer_high_address[7:0] == o_pointer_low_address[7:0] + 8'd1))
        else $error("pointer high address left the page of the low address");
`endif

endmodule
`default_nettype wire

[src/cea_front.sv]
// First two pipeline stages: mode decode and index select, then the address adds.
`default_nettype none
module cea_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [3:0]     i_action,
    input  wire logic [15:0]    i_pc,
    input  wire logic [7:0]     i_index_x,
    input  wire logic [7:0]     i_index_y,
    input  wire logic [7:0]     i_operand_low,
    input  wire logic [7:0]     i_operand_high,
    input  wire logic [7:0]     i_pointer_low,
    input  wire logic [7:0]     i_pointer_high,
    output cea_pkg::t_s2        o_s2
);
    import cea_pkg::*;

    logic        r1_valid;
    logic [3:0]  r1_mode;
    logic [15:0] r1_npc;
    logic [15:0] r1_word;
    logic [15:0] r1_ptrw;
    logic [7:0]  r1_zidx;
    logic [7:0]  r1_widx;
    t_s2         r_s2;

    logic [1:0]  n_inc;
    logic [7:0]  n_zidx;
    logic [7:0]  n_widx;
    t_s2         n_s2;

    // Stage one: pick PC advance and the index for the zero-page and word adds.
    always_comb begin
        n_inc  = 2'd0;
        n_zidx = 8'd0;
        n_widx = 8'd0;
        unique case (i_action) inside
            MODE_IMM, MODE_ZP, MODE_REL: begin
                n_inc = 2'd1;
            end
            MODE_ZPX, MODE_INDX: begin
                n_inc  = 2'd1;
                n_zidx = i_index_x;
            end
            MODE_ZPY: begin
                n_inc  = 2'd1;
                n_zidx = i_index_y;
            end
            MODE_INDY: begin
                n_inc  = 2'd1;
                n_widx = i_index_y;
            end
            MODE_ABS, MODE_IND: begin
                n_inc = 2'd2;
            end
            MODE_ABSX: begin
                n_inc  = 2'd2;
                n_widx = i_index_x;
            end
            MODE_ABSY: begin
                n_inc  = 2'd2;
                n_widx = i_index_y;
            end
            default: begin
                n_inc = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_mode <= i_action;
        r1_npc  <= i_pc + {14'd0, n_inc};
        r1_word <= {i_operand_high, i_operand_low};
        r1_ptrw <= {i_pointer_high, i_pointer_low};
        r1_zidx <= n_zidx;
        r1_widx <= n_widx;
    end

    // Stage two: the wide adds, one per result path.
    always_comb begin
        n_s2.valid   = r1_valid;
        n_s2.mode    = r1_mode;
        n_s2.npc     = r1_npc;
        n_s2.word    = r1_word;
        n_s2.ptrw    = r1_ptrw;
        n_s2.abs_sum = r1_word + {8'd0, r1_widx};
        n_s2.ptr_sum = r1_ptrw + {8'd0, r1_widx};
        n_s2.rel_sum = r1_npc + {{8{r1_word[7]}}, r1_word[7:0]};
        n_s2.zp      = r1_word[7:0] + r1_zidx;
        n_s2.zp_next = r1_word[7:0] + r1_zidx + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
        r_s2.mode    <= n_s2.mode;
        r_s2.npc     <= n_s2.npc;
        r_s2.word    <= n_s2.word;
        r_s2.ptrw    <= n_s2.ptrw;
        r_s2.abs_sum <= n_s2.abs_sum;
        r_s2.ptr_sum <= n_s2.ptr_sum;
        r_s2.rel_sum <= n_s2.rel_sum;
        r_s2.zp      <= n_s2.zp;
        r_s2.zp_next <= n_s2.zp_next;
    end

    assign o_s2 = r_s2;

endmodule
`default_nettype wire

[tb/ea_checker.sv]
// Scoreboard for the effective address block: predicts every request beat and checks results.
module ea_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [3:0]  i_action,
    input  wire logic [15:0] i_pc,
    input  wire logic [7:0]  i_index_x,
    input  wire logic [7:0]  i_index_y,
    input  wire logic [7:0]  i_operand_low,
    input  wire logic [7:0]  i_operand_high,
    input  wire logic [7:0]  i_pointer_low,
    input  wire logic [7:0]  i_pointer_high,
    input  wire logic        i_res_valid,
    input  wire logic [15:0] i_res_effective_address,
    input  wire logic [15:0] i_res_next_pc,
    input  wire logic        i_res_cross_page,
    input  wire logic [15:0] i_res_pointer_low_address,
    input  wire logic [15:0] i_res_pointer_high_address,
    input  wire logic        i_res_uses_pointer,
    output int               o_failures,
    output int               o_pending,
    output int               o_checked
);
    import cea_pkg::*;

    typedef struct packed {
        logic [15:0] ea;
        logic [15:0] npc;
        logic        crossed;
        logic [15:0] ptr_lo_addr;
        logic [15:0] ptr_hi_addr;
        logic        uses_ptr;
    } t_addr_result;

    t_addr_result expected_addr_q[$];
    int           mismatch_count = 0;
    int           result_count = 0;

    function automatic t_addr_result predict_address(
        input logic [3:0]  mode,
        input logic [15:0] pc,
        input logic [7:0]  x,
        input logic [7:0]  y,
        input logic [7:0]  lo,
        input logic [7:0]  hi,
        input logic [7:0]  plo,
        input logic [7:0]  phi
    );
        t_addr_result r;
        logic [15:0]  word;
        logic [15:0]  ptrw;
        logic [7:0]   zp;
        word  = {hi, lo};
        ptrw  = {phi, plo};
        r     = '0;
        r.npc = pc;
        case (mode)
            MODE_IMM: begin
                r.ea  = pc;
                r.npc = pc + 16'd1;
            end
            MODE_ZP: begin
                r.ea  = {8'h00, lo};
                r.npc = pc + 16'd1;
            end
            MODE_ZPX: begin
                zp    = lo + x;
                r.ea  = {8'h00, zp};
                r.npc = pc + 16'd1;
            end
            MODE_ZPY: begin
                zp    = lo + y;
                r.ea  = {8'h00, zp};
                r.npc = pc + 16'd1;
            end
            MODE_ABS: begin
                r.ea  = word;
                r.npc = pc + 16'd2;
            end
            MODE_ABSX: begin
                r.ea      = word + {8'h00, x};
                r.npc     = pc + 16'd2;
                r.crossed = (word[15:8] != r.ea[15:8]);
            end
            MODE_ABSY: begin
                r.ea      = word + {8'h00, y};
                r.npc     = pc + 16'd2;
                r.crossed = (word[15:8] != r.ea[15:8]);
            end
            MODE_IND: begin
                // pointer at the end of a page fetches its high byte from the page start
                r.npc         = pc + 16'd2;
                r.uses_ptr    = 1'b1;
                r.ptr_lo_addr = word;
                r.ptr_hi_addr = (word[7:0] == 8'hFF) ? {word[15:8], 8'h00} : word + 16'd1;
                r.ea          = ptrw;
            end
            MODE_INDX: begin
                r.npc         = pc + 16'd1;
                r.uses_ptr    = 1'b1;
                zp            = lo + x;
                r.ptr_lo_addr = {8'h00, zp};
                zp            = zp + 8'd1;
                r.ptr_hi_addr = {8'h00, zp};
                r.ea          = ptrw;
            end
            MODE_INDY: begin
                r.npc         = pc + 16'd1;
                r.uses_ptr    = 1'b1;
                r.ptr_lo_addr = {8'h00, lo};
                zp            = lo + 8'd1;
                r.ptr_hi_addr = {8'h00, zp};
                r.ea          = ptrw + {8'h00, y};
                r.crossed     = (ptrw[15:8] != r.ea[15:8]);
            end
            MODE_REL: begin
                r.npc = pc + 16'd1;
                r.ea  = r.npc + {{8{lo[7]}}, lo};
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d: %s expected %h, got %h", result_count, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_addr_result want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                expected_addr_q.push_back(predict_address(i_action, i_pc, i_index_x,
                    i_index_y, i_operand_low, i_operand_high, i_pointer_low,
                    i_pointer_high));
            if (i_res_valid) begin
                if (expected_addr_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result beat with no request waiting, ea %h",
                                 i_res_effective_address);
                end else begin
                    want = expected_addr_q.pop_front();
                    check_field("effective_address", want.ea, i_res_effective_address);
                    check_field("next_pc", want.npc, i_res_next_pc);
                    check_field("cross_page", {15'd0, want.crossed},
                                {15'd0, i_res_cross_page});
                    check_field("pointer_low_address", want.ptr_lo_addr,
                                i_res_pointer_low_address);
                    check_field("pointer_high_address", want.ptr_hi_addr,
                                i_res_pointer_high_address);
                    check_field("uses_pointer", {15'd0, want.uses_ptr},
                                {15'd0, i_res_uses_pointer});
                    result_count++;
                end
            end
        end
        o_failures = mismatch_count;
        o_pending  = expected_addr_q.size();
        o_checked  = result_count;
    end

endmodule

[tb/testbench.sv]
// Top of the effective address testbench: clock, reset, request stimulus and verdict.
module testbench;
    import cea_pkg::*;

    // mode "none"; codes above it are unused and must behave the same way
    localparam logic [3:0] MODE_NONE   = 4'd11;
    localparam int         STALL_LIMIT = 200;
    localparam int         DRAIN_WAIT  = 8;
    localparam int         RANDOM_BEATS_PER_PHASE = 184;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_action = '0;
    logic [15:0] i_pc = '0;
    logic [7:0]  i_index_x = '0;
    logic [7:0]  i_index_y = '0;
    logic [7:0]  i_operand_low = '0;
    logic [7:0]  i_operand_high = '0;
    logic [7:0]  i_pointer_low = '0;
    logic [7:0]  i_pointer_high = '0;
    logic        o_valid;
    logic [15:0] o_effective_address;
    logic [15:0] o_next_pc;
    logic        o_cross_page;
    logic [15:0] o_pointer_low_address;
    logic [15:0] o_pointer_high_address;
    logic        o_uses_pointer;

    int          failures;
    int          pending;
    int          checked;
    int          beats_sent = 0;
    int          stall_cycles = 0;
    bit          mode_seen [16];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    cpu6502_effective_address uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_action               (i_action),
        .i_pc                   (i_pc),
        .i_index_x              (i_index_x),
        .i_index_y              (i_index_y),
        .i_operand_low          (i_operand_low),
        .i_operand_high         (i_operand_high),
        .i_pointer_low          (i_pointer_low),
        .i_pointer_high         (i_pointer_high),
        .o_valid                (o_valid),
        .o_effective_address    (o_effective_address),
        .o_next_pc              (o_next_pc),
        .o_cross_page           (o_cross_page),
        .o_pointer_low_address  (o_pointer_low_address),
        .o_pointer_high_address (o_pointer_high_address),
        .o_uses_pointer         (o_uses_pointer)
    );

    ea_checker addr_check (
        .i_clk                      (i_clk),
        .i_rst_n                    (i_rst_n),
        .i_start                    (start),
        .i_busy                     (busy),
        .i_action                   (i_action),
        .i_pc                       (i_pc),
        .i_index_x                  (i_index_x),
        .i_index_y                  (i_index_y),
        .i_operand_low              (i_operand_low),
        .i_operand_high             (i_operand_high),
        .i_pointer_low              (i_pointer_low),
        .i_pointer_high             (i_pointer_high),
        .i_res_valid                (o_valid),
        .i_res_effective_address    (o_effective_address),
        .i_res_next_pc              (o_next_pc),
        .i_res_cross_page           (o_cross_page),
        .i_res_pointer_low_address  (o_pointer_low_address),
        .i_res_pointer_high_address (o_pointer_high_address),
        .i_res_uses_pointer         (o_uses_pointer),
        .o_failures                 (failures),
        .o_pending                  (pending),
        .o_checked                  (checked)
    );

    // Watchdog: restart on every accepted request or result beat, abort when
    // the block goes quiet for far longer than any sender gap plus latency.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Skew toward the values where wraps and page crossings happen.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'hFFFE;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Present one request beat and hold it until the block takes it. With
    // idle_pct > 0, drop start for a random gap first; the gap length is
    // geometric so that idle cycles make up about idle_pct of the time.
    task automatic send_beat(
        input logic [3:0]  mode,
        input logic [15:0] pc,
        input logic [7:0]  x,
        input logic [7:0]  y,
        input logic [7:0]  lo,
        input logic [7:0]  hi,
        input logic [7:0]  plo,
        input logic [7:0]  phi,
        input int          idle_pct
    );
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(1, 100) <= idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= mode;
        i_pc           <= pc;
        i_index_x      <= x;
        i_index_y      <= y;
        i_operand_low  <= lo;
        i_operand_high <= hi;
        i_pointer_low  <= plo;
        i_pointer_high <= phi;
        // busy read right after the edge is the value the block saw at it
        do @(posedge i_clk); while (busy);
        beats_sent++;
        mode_seen[mode] = 1'b1;
    endtask

    task automatic random_phase(input int idle_pct);
        logic [3:0] mode;
        repeat (RANDOM_BEATS_PER_PHASE) begin
            // mostly defined modes, with the unused codes mixed in now and then
            if ($urandom_range(0, 7) != 0)
                mode = 4'($urandom_range(0, 11));
            else
                mode = 4'($urandom_range(12, 15));
            send_beat(mode, pick_word(), pick_byte(), pick_byte(), pick_byte(),
                      pick_byte(), pick_byte(), pick_byte(), idle_pct);
        end
    endtask

    initial begin
        int modes_hit;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats, back to back.
        // immediate with PC wrapping past the top of memory
        send_beat(MODE_IMM,  16'hFFFF, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h00, 0);
        send_beat(MODE_ZP,   16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        // zero page indexed wraps inside page zero
        send_beat(MODE_ZPX,  16'h1234, 8'h01, 8'h00, 8'hFF, 8'h12, 8'h00, 8'h00, 0);
        send_beat(MODE_ZPY,  16'h8000, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 0);
        // absolute with the operand fetch wrapping the PC
        send_beat(MODE_ABS,  16'hFFFE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 0);
        // indexed absolute: crossing, no crossing at max index, 16-bit wrap
        send_beat(MODE_ABSX, 16'h0200, 8'h01, 8'h00, 8'hFF, 8'h12, 8'h00, 8'h00, 0);
        send_beat(MODE_ABSX, 16'h0200, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h00, 8'h00, 0);
        send_beat(MODE_ABSX, 16'h0200, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 0);
        send_beat(MODE_ABSY, 16'h0300, 8'h00, 8'h10, 8'hF0, 8'h34, 8'h00, 8'h00, 0);
        // indirect: page-wrap quirk, plain pointer, pointer at the top of memory
        send_beat(MODE_IND,  16'h0400, 8'h00, 8'h00, 8'hFF, 8'h02, 8'h34, 8'h12, 0);
        send_beat(MODE_IND,  16'h0400, 8'h00, 8'h00, 8'h10, 8'h02, 8'hCD, 8'hAB, 0);
        send_beat(MODE_IND,  16'hFFFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        // indexed indirect: pointer at the end of page zero wraps for its high byte
        send_beat(MODE_INDX, 16'h0500, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h80, 0);
        send_beat(MODE_INDX, 16'h0500, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h11, 8'h22, 0);
        // indirect indexed: crossing with full wrap, then no crossing
        send_beat(MODE_INDY, 16'h0600, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 0);
        send_beat(MODE_INDY, 16'h0600, 8'h00, 8'h00, 8'h10, 8'h00, 8'h34, 8'h12, 0);
        // relative: most negative and most positive offsets, plus zero
        send_beat(MODE_REL,  16'h0000, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 0);
        send_beat(MODE_REL,  16'hFFFF, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 0);
        send_beat(MODE_REL,  16'h1000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        // none and unused codes: everything zero, PC unchanged
        send_beat(MODE_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        send_beat(4'd12,     16'h1234, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 0);
        send_beat(4'd15,     16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);

        // Random beats: full rate, sender idle most of the time, then a third.
        random_phase(0);
        random_phase(65);
        random_phase(34);

        // Drop start and let the pipeline drain; sample the count mid-cycle.
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        modes_hit = 0;
        foreach (mode_seen[m])
            if (mode_seen[m])
                modes_hit++;
        $display("sent %0d request beats covering %0d of 16 mode codes", beats_sent,
                 modes_hit);
        $display("compared %0d result beats, %0d field mismatches", checked, failures);
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[files.f]
src/cea_pkg.sv
src/cea_front.sv
src/cpu6502_effective_address.sv
tb/ea_checker.sv
tb/testbench.sv
